// ===== rtl/rhvg_pkg.sv =====
// Package for the return-home velocity guidance block: sequencer states, register map, defaults.
package rhvg_pkg;

  localparam int COMPLETE_TICKS_DEF = 50;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_HOME_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_R = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_R = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DONE_GS = 8'd7;

  localparam logic [15:0] CRUISE_RST = 16'd5000;
  localparam logic [15:0] DECEL_RST = 16'd1000;
  localparam logic [19:0] NEAR_R_RST = 20'd5000;
  localparam logic [15:0] MAX_STEP_RST = 16'd40;
  localparam logic [19:0] HOME_R_RST = 20'd1000;
  localparam logic [15:0] DONE_GS_RST = 16'd300;

  localparam logic [31:0] DIR_MIN_DIST = 32'd10;
  localparam logic signed [19:0] CMD_LIM = 20'sd131071;
  localparam logic signed [17:0] OUT_LIM = 18'sd65535;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 18;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_SQC, ST_SQRT, ST_DIV, ST_ARRIVE, ST_BRK, ST_SPD,
    ST_NDIV, ST_NQ, ST_WX, ST_XDIV, ST_XQ, ST_YDIV, ST_YQ, ST_DV, ST_MSQA,
    ST_MSQB, ST_MSQC, ST_MAG, ST_SXDIV, ST_SXQ, ST_SYDIV, ST_SYQ, ST_UPD, ST_OUT
  } rhvg_state_t;

endpackage

// ===== rtl/return_home_velocity_guidance.sv =====
// Return-home velocity guidance: bit-serial sequencer for distance, target speed and step limit.
//
// Usage: one input beat per control tick on s_* carries the position, ground speed and a
// restart flag; one result beat on m_* carries the smoothed velocity command, the distance
// to home and the completion flag. Registers are written on the cfg_* channel (index, data);
// the user must write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high. Each beat runs through a sequencer around one shared multiplier
// and one shift register unit that works as a restoring square root (2 bits per cycle) or
// as a restoring divider (1 quotient bit per cycle). A full tick runs three square roots
// and up to five divisions between acceptance and the result register; once complete,
// a tick computes the distance only.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, so a new beat is taken while m_tready is low, and the sequencer holds
// in its last state until the output register frees up.
// Reset (rst, synchronous) restores the register defaults, clears the velocity command,
// the near-home counter and the completion flag, and empties the output register.
module return_home_velocity_guidance #(
  parameter int COMPLETE_TICKS = rhvg_pkg::COMPLETE_TICKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x[30:0], pos_y[61:31], ground_speed[77:62], restart[78], zero[79]
  input  logic [rhvg_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // vel_x_cmd[16:0], vel_y_cmd[33:17], distance[65:34], complete[66], zero[71:67]
  output logic [rhvg_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rhvg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhvg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rhvg_pkg::*;

  localparam logic [15:0] CT = 16'(COMPLETE_TICKS);

  logic signed [30:0] home_x, home_y;
  logic [15:0] cruise_speed, brake_decel, max_step, done_ground_speed;
  logic [19:0] near_radius, home_radius;

  logic signed [17:0] cmd_vx, cmd_vy;
  logic [15:0] near_ticks;
  logic done_flag;

  rhvg_state_t state, state_next, after;
  logic [30:0] ax, ay;
  logic neg_x, neg_y;
  logic [15:0] gs;
  logic [63:0] prod, acc, rad;
  logic [35:0] rem;
  logic [31:0] root, dist_mm;
  logic [32:0] dvs;
  logic [4:0] cnt;
  logic [15:0] speed;
  logic signed [16:0] wx, wy;
  logic signed [18:0] dvx, dvy;
  logic [18:0] mag;

  logic [31:0] mul_a, mul_b;
  logic [63:0] sqrt_in, div_in;
  logic [35:0] sq_sh, sq_tr, dv_sh;
  logic sq_ge, dv_ge;
  logic [17:0] ux, uy;
  logic near;
  logic [15:0] nt_new, spd_min;
  logic signed [31:0] diff_x, diff_y;
  logic signed [19:0] sum_x, sum_y;
  logic signed [17:0] out_x, out_y;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);

  assign diff_x = {home_x[30], home_x} - {s_tdata[30], s_tdata[30:0]};
  assign diff_y = {home_y[30], home_y} - {s_tdata[61], s_tdata[61:31]};

  assign ux = dvx[18] ? 18'(-dvx) : dvx[17:0];
  assign uy = dvy[18] ? 18'(-dvy) : dvy[17:0];

  assign sq_sh = {rem[33:0], rad[63:62]};
  assign sq_tr = {2'b00, root, 2'b01};
  assign sq_ge = sq_sh >= sq_tr;
  assign dv_sh = {rem[34:0], rad[63]};
  assign dv_ge = dv_sh >= {3'b000, dvs};

  assign near = root <= {12'd0, home_radius};
  always_comb begin
    if (!near) begin
      nt_new = '0;
    end else if (near_ticks < CT) begin
      nt_new = near_ticks + 16'd1;
    end else begin
      nt_new = near_ticks;
    end
  end

  assign spd_min = (root > {16'd0, cruise_speed}) ? cruise_speed : root[15:0];

  assign sum_x = {{2{cmd_vx[17]}}, cmd_vx} + {dvx[18], dvx};
  assign sum_y = {{2{cmd_vy[17]}}, cmd_vy} + {dvy[18], dvy};

  always_comb begin
    if (cmd_vx > OUT_LIM) begin
      out_x = OUT_LIM;
    end else if (cmd_vx < -OUT_LIM) begin
      out_x = -OUT_LIM;
    end else begin
      out_x = cmd_vx;
    end
    if (cmd_vy > OUT_LIM) begin
      out_y = OUT_LIM;
    end else if (cmd_vy < -OUT_LIM) begin
      out_y = -OUT_LIM;
    end else begin
      out_y = cmd_vy;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sqrt_in = acc + prod;
    div_in = prod;
    case (state)
      ST_SQA: begin
        mul_a = {1'b0, ax};
        mul_b = {1'b0, ax};
      end
      ST_SQB: begin
        mul_a = {1'b0, ay};
        mul_b = {1'b0, ay};
      end
      ST_ARRIVE: begin
        mul_a = {16'd0, brake_decel};
        mul_b = root;
      end
      ST_BRK: sqrt_in = {prod[62:0], 1'b0};
      ST_SPD: begin
        mul_a = {16'd0, spd_min};
        mul_b = dist_mm;
      end
      ST_WX: begin
        mul_a = {1'b0, ax};
        mul_b = {16'd0, speed};
      end
      ST_XDIV, ST_YDIV: div_in = {prod[62:0], 1'b0} + {32'd0, dist_mm};
      ST_XQ: begin
        mul_a = {1'b0, ay};
        mul_b = {16'd0, speed};
      end
      ST_MSQA: begin
        mul_a = {14'd0, ux};
        mul_b = {14'd0, ux};
      end
      ST_MSQB: begin
        mul_a = {14'd0, uy};
        mul_b = {14'd0, uy};
      end
      ST_MAG: begin
        mul_a = {14'd0, ux};
        mul_b = {16'd0, max_step};
      end
      ST_SXQ: begin
        mul_a = {14'd0, uy};
        mul_b = {16'd0, max_step};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_SQA;
      ST_SQA: state_next = ST_SQB;
      ST_SQB: state_next = ST_SQC;
      ST_SQC: state_next = ST_SQRT;
      ST_SQRT, ST_DIV: if (cnt == 5'd0) state_next = after;
      ST_ARRIVE: state_next = done_flag ? ST_OUT : ST_BRK;
      ST_BRK: state_next = ST_SQRT;
      ST_SPD: state_next = (dist_mm < {12'd0, near_radius}) ? ST_NDIV : ST_WX;
      ST_NDIV: state_next = ST_DIV;
      ST_NQ: state_next = ST_WX;
      ST_WX: state_next = (dist_mm > DIR_MIN_DIST) ? ST_XDIV : ST_DV;
      ST_XDIV: state_next = ST_DIV;
      ST_XQ: state_next = ST_YDIV;
      ST_YDIV: state_next = ST_DIV;
      ST_YQ: state_next = ST_DV;
      ST_DV: state_next = ST_MSQA;
      ST_MSQA: state_next = ST_MSQB;
      ST_MSQB: state_next = ST_MSQC;
      ST_MSQC: state_next = ST_SQRT;
      ST_MAG: state_next = (root > {16'd0, max_step}) ? ST_SXDIV : ST_UPD;
      ST_SXDIV: state_next = ST_DIV;
      ST_SXQ: state_next = ST_SYDIV;
      ST_SYDIV: state_next = ST_DIV;
      ST_SYQ: state_next = ST_UPD;
      ST_UPD: state_next = ST_OUT;
      ST_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_x <= '0;
      home_y <= '0;
      cruise_speed <= CRUISE_RST;
      brake_decel <= DECEL_RST;
      near_radius <= NEAR_R_RST;
      max_step <= MAX_STEP_RST;
      home_radius <= HOME_R_RST;
      done_ground_speed <= DONE_GS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOME_X: home_x <= cfg_data[30:0];
        REG_HOME_Y: home_y <= cfg_data[30:0];
        REG_CRUISE: cruise_speed <= cfg_data[15:0];
        REG_DECEL: brake_decel <= cfg_data[15:0];
        REG_NEAR_R: near_radius <= cfg_data[19:0];
        REG_MAX_STEP: max_step <= cfg_data[15:0];
        REG_HOME_R: home_radius <= cfg_data[19:0];
        REG_DONE_GS: done_ground_speed <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vx <= '0;
      cmd_vy <= '0;
      near_ticks <= '0;
      done_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tdata[78]) begin
            cmd_vx <= '0;
            cmd_vy <= '0;
            near_ticks <= '0;
            done_flag <= 1'b0;
          end
        end
        ST_ARRIVE: begin
          if (!done_flag) begin
            near_ticks <= nt_new;
            done_flag <= near && (gs <= done_ground_speed || nt_new >= CT);
          end
        end
        ST_UPD: begin
          if (sum_x > CMD_LIM) begin
            cmd_vx <= CMD_LIM[17:0];
          end else if (sum_x < -CMD_LIM) begin
            cmd_vx <= 18'(-CMD_LIM);
          end else begin
            cmd_vx <= sum_x[17:0];
          end
          if (sum_y > CMD_LIM) begin
            cmd_vy <= CMD_LIM[17:0];
          end else if (sum_y < -CMD_LIM) begin
            cmd_vy <= 18'(-CMD_LIM);
          end else begin
            cmd_vy <= sum_y[17:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        neg_x <= diff_x[31];
        neg_y <= diff_y[31];
        ax <= diff_x[31] ? 31'(-diff_x) : diff_x[30:0];
        ay <= diff_y[31] ? 31'(-diff_y) : diff_y[30:0];
        gs <= s_tdata[77:62];
      end
      ST_SQB, ST_MSQB: acc <= prod;
      ST_SQC, ST_BRK, ST_MSQC: begin
        rad <= sqrt_in;
        rem <= '0;
        root <= '0;
        cnt <= 5'(SQRT_STEPS - 1);
        case (state)
          ST_SQC: after <= ST_ARRIVE;
          ST_BRK: after <= ST_SPD;
          default: after <= ST_MAG;
        endcase
      end
      ST_NDIV, ST_XDIV, ST_YDIV, ST_SXDIV, ST_SYDIV: begin
        rad <= {div_in[DIV_STEPS-1:0], {(64-DIV_STEPS){1'b0}}};
        rem <= div_in[DIV_STEPS+35:DIV_STEPS];
        root <= '0;
        cnt <= 5'(DIV_STEPS - 1);
        case (state)
          ST_NDIV: begin
            dvs <= {13'd0, near_radius};
            after <= ST_NQ;
          end
          ST_XDIV: begin
            dvs <= {dist_mm, 1'b0};
            after <= ST_XQ;
          end
          ST_YDIV: begin
            dvs <= {dist_mm, 1'b0};
            after <= ST_YQ;
          end
          ST_SXDIV: begin
            dvs <= {14'd0, mag};
            after <= ST_SXQ;
          end
          default: begin
            dvs <= {14'd0, mag};
            after <= ST_SYQ;
          end
        endcase
      end
      ST_SQRT: begin
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt - 5'd1;
        if (sq_ge) begin
          rem <= sq_sh - sq_tr;
          root <= {root[30:0], 1'b1};
        end else begin
          rem <= sq_sh;
          root <= {root[30:0], 1'b0};
        end
      end
      ST_DIV: begin
        rad <= {rad[62:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (dv_ge) begin
          rem <= dv_sh - {3'b000, dvs};
          root <= {root[30:0], 1'b1};
        end else begin
          rem <= dv_sh;
          root <= {root[30:0], 1'b0};
        end
      end
      ST_ARRIVE: dist_mm <= root;
      ST_SPD: speed <= spd_min;
      ST_NQ: speed <= root[15:0];
      ST_WX: begin
        wx <= '0;
        wy <= '0;
      end
      ST_XQ: wx <= neg_x ? -$signed(root[16:0]) : $signed(root[16:0]);
      ST_YQ: wy <= neg_y ? -$signed(root[16:0]) : $signed(root[16:0]);
      ST_DV: begin
        dvx <= {{2{wx[16]}}, wx} - {cmd_vx[17], cmd_vx};
        dvy <= {{2{wy[16]}}, wy} - {cmd_vy[17], cmd_vy};
      end
      ST_MAG: mag <= root[18:0];
      ST_SXQ: dvx <= dvx[18] ? -$signed({2'b00, root[16:0]}) : $signed({2'b00, root[16:0]});
      ST_SYQ: dvy <= dvy[18] ? -$signed({2'b00, root[16:0]}) : $signed({2'b00, root[16:0]});
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {5'd0, done_flag, dist_mm, out_y[16:0], out_x[16:0]};
        end
      end
      default: ;
    endcase
  end

endmodule
